// ===== hw/rtl/ntc_pkg.sv =====
package ntc_pkg;

   // Field and register widths fixed by the interface
   localparam int CODE_W    = 12;
   localparam int BETA_W    = 14;
   localparam int T0_W      = 16;
   localparam int SCALE_W   = 13;
   localparam int RATIO_W   = 16;
   localparam int TEMP_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int ADC_BITS_DEF  = 12;
   localparam int FRAC_BITS_DEF = 16;

   // round(ln2 * 2^30)
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   localparam int ZERO_C_CK = 27315;
   localparam int TEMP_MAX  = 32767;
   localparam int TCK_MAX   = TEMP_MAX + ZERO_C_CK;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_LOW  = 2'd1,
      FAULT_HIGH = 2'd2
   } fault_kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BETA  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_T0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH  = 3'd4;

   localparam logic [BETA_W-1:0]  BETA_RST  = 14'd3470;
   localparam logic [T0_W-1:0]    T0_RST    = 16'd29815;
   localparam logic [SCALE_W-1:0] SCALE_RST = 13'd256;
   localparam logic [CODE_W-1:0]  LOW_RST   = 12'd12;
   localparam logic [CODE_W-1:0]  HIGH_RST  = 12'd4083;

endpackage

// ===== hw/rtl/ntc_adc_to_celsius.sv =====
// NTC divider ADC code to temperature in hundredths of a degree Celsius.
// The pipeline holds the two 16-step dividers, one squaring stage per log fraction bit
// and the nibble-wide divide by 100.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module ntc_adc_to_celsius #(
   parameter int ADC_BITS  = ntc_pkg::ADC_BITS_DEF,
   parameter int FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] raw_code, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] temp_centi_c
   output logic [2:0]  rsp_tuser,   // [0] reading_ok, [2:1] fault_kind
   input  logic        csr_we,
   input  logic [ntc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ntc_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int CODE_W  = ntc_pkg::CODE_W;
   localparam int RATIO_W = ntc_pkg::RATIO_W;
   localparam int WW   = (ADC_BITS > CODE_W) ? ADC_BITS : CODE_W;
   localparam int N1W  = ntc_pkg::SCALE_W + ADC_BITS;
   localparam int D1W  = (N1W > CODE_W + RATIO_W) ? N1W : CODE_W + RATIO_W;
   localparam int MW   = FRAC_BITS + 4;
   localparam int LPW  = MW + 30;
   localparam int PW   = ntc_pkg::T0_W + MW;
   localparam int NS   = (PW + 3) / 4;
   localparam int PADW = NS * 4;
   localparam int BSW  = ntc_pkg::BETA_W + FRAC_BITS;
   localparam int DNW  = ((BSW > PADW) ? BSW : PADW) + 2;
   localparam int DUW  = DNW - 1;
   localparam int KW   = ntc_pkg::T0_W + ntc_pkg::BETA_W;
   localparam int NKW  = KW + FRAC_BITS;
   localparam int NW   = ((NKW > DUW) ? NKW : DUW) + 1;
   localparam int RW2  = (NW > DUW + 16) ? NW : DUW + 16;
   localparam logic [WW-1:0] FULL = WW'((64'd1 << ADC_BITS) - 64'd1);

   typedef ntc_pkg::fault_kind_type kind_type;

   // ---------------------------------------------------------------- registers
   logic [ntc_pkg::BETA_W-1:0]  beta_ff;
   logic [ntc_pkg::T0_W-1:0]    t0_ff;
   logic [ntc_pkg::SCALE_W-1:0] scale_ff;
   logic [CODE_W-1:0]           low_ff;
   logic [CODE_W-1:0]           high_ff;
   logic [KW-1:0]               numk_ff;   // T0 * B, registered from t0_ff and beta_ff

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff  <= ntc_pkg::BETA_RST;
         t0_ff    <= ntc_pkg::T0_RST;
         scale_ff <= ntc_pkg::SCALE_RST;
         low_ff   <= ntc_pkg::LOW_RST;
         high_ff  <= ntc_pkg::HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ntc_pkg::CSR_BETA:  beta_ff  <= csr_wdata[ntc_pkg::BETA_W-1:0];
            ntc_pkg::CSR_T0:    t0_ff    <= csr_wdata[ntc_pkg::T0_W-1:0];
            ntc_pkg::CSR_SCALE: scale_ff <= csr_wdata[ntc_pkg::SCALE_W-1:0];
            ntc_pkg::CSR_LOW:   low_ff   <= csr_wdata[CODE_W-1:0];
            ntc_pkg::CSR_HIGH:  high_ff  <= csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      numk_ff <= KW'(t0_ff) * KW'(beta_ff);
   end

   // Every stage advances together; hold all of them while the result waits.
   logic adv;
   logic rsp_tvalid_ff;
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------------------------------------------------------- stage A
   // Clamp the code, classify the windows, form scale * (full - code).
   logic              a_v_ff;
   kind_type          a_kind_ff;
   logic [N1W-1:0]    a_num_ff;
   logic [CODE_W-1:0] a_code_ff;
   logic [WW-1:0]     a_codew;
   logic [WW-1:0]     a_codec;
   logic [WW-1:0]     a_diff;
   kind_type          a_kind_in;

   always_comb begin
      a_codew = WW'(req_tdata[CODE_W-1:0]);
      a_codec = (a_codew > FULL) ? FULL : a_codew;
      a_diff  = FULL - a_codec;
      if (a_codec[CODE_W-1:0] <= low_ff) begin
         a_kind_in = ntc_pkg::FAULT_LOW;
      end else if (a_codec[CODE_W-1:0] >= high_ff) begin
         a_kind_in = ntc_pkg::FAULT_HIGH;
      end else begin
         a_kind_in = ntc_pkg::FAULT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_kind_ff <= a_kind_in;
         a_num_ff  <= N1W'(scale_ff) * N1W'(a_diff[ADC_BITS-1:0]);
         a_code_ff <= a_codec[CODE_W-1:0];
      end
   end

   // ---------------------------------------------------------------- ratio divider
   // Index 0 is stage B: flag a quotient that will not fit 16 bits.
   logic               d1_v_ff    [0:RATIO_W];
   kind_type           d1_kind_ff [0:RATIO_W];
   logic               d1_sat_ff  [0:RATIO_W];
   logic [D1W-1:0]     d1_rem_ff  [0:RATIO_W];
   logic [CODE_W-1:0]  d1_code_ff [0:RATIO_W];
   logic [RATIO_W-1:0] d1_q_ff    [0:RATIO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff[0] <= 1'b0;
      end else if (adv) begin
         d1_v_ff[0] <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_kind_ff[0] <= a_kind_ff;
         d1_sat_ff[0]  <= D1W'(a_num_ff) >= (D1W'(a_code_ff) << RATIO_W);
         d1_rem_ff[0]  <= D1W'(a_num_ff);
         d1_code_ff[0] <= a_code_ff;
         d1_q_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < RATIO_W; k++) begin : g_div1
      logic [D1W-1:0] trial;
      logic           take;

      always_comb begin
         trial = D1W'(d1_code_ff[k]) << (RATIO_W - 1 - k);
         take  = d1_rem_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            d1_v_ff[k+1] <= d1_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d1_kind_ff[k+1] <= d1_kind_ff[k];
            d1_sat_ff[k+1]  <= d1_sat_ff[k];
            d1_rem_ff[k+1]  <= take ? d1_rem_ff[k] - trial : d1_rem_ff[k];
            d1_code_ff[k+1] <= d1_code_ff[k];
            d1_q_ff[k+1]    <= {d1_q_ff[k][RATIO_W-2:0], take};
         end
      end
   end

   // ---------------------------------------------------------------- log2 setup
   // Saturate the ratio, find its leading one and normalize to Q1.30; a zero ratio faults high.
   logic [RATIO_W-1:0] lr_ratio;
   logic [3:0]         lr_p;
   kind_type           lr_kind;

   always_comb begin
      lr_ratio = d1_sat_ff[RATIO_W] ? '1 : d1_q_ff[RATIO_W];
      lr_p     = 4'd0;
      for (int b = 0; b < RATIO_W; b++) begin
         if (lr_ratio[b]) begin
            lr_p = 4'(b);
         end
      end
      lr_kind = d1_kind_ff[RATIO_W];
      if (lr_kind == ntc_pkg::FAULT_NONE && lr_ratio == '0) begin
         lr_kind = ntc_pkg::FAULT_HIGH;
      end
   end

   // ---------------------------------------------------------------- squaring chain
   // One fraction bit per stage: square, and renormalize when it reaches 2.
   logic                 sq_v_ff    [0:FRAC_BITS];
   kind_type             sq_kind_ff [0:FRAC_BITS];
   logic [3:0]           sq_p_ff    [0:FRAC_BITS];
   logic [30:0]          sq_m_ff    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] sq_frac_ff [0:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= d1_v_ff[RATIO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_kind_ff[0] <= lr_kind;
         sq_p_ff[0]    <= lr_p;
         sq_m_ff[0]    <= 31'(lr_ratio) << (5'd30 - {1'b0, lr_p});
         sq_frac_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
      logic [61:0] prod;
      logic [31:0] m2;

      always_comb begin
         prod = 62'(sq_m_ff[j]) * 62'(sq_m_ff[j]);
         m2   = prod[61:30];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_kind_ff[j+1] <= sq_kind_ff[j];
            sq_p_ff[j+1]    <= sq_p_ff[j];
            sq_m_ff[j+1]    <= m2[31] ? m2[31:1] : m2[30:0];
            sq_frac_ff[j+1] <= {sq_frac_ff[j][FRAC_BITS-2:0], m2[31]};
         end
      end
   end

   // ---------------------------------------------------------------- magnitude of log2
   logic          mg_v_ff;
   kind_type      mg_kind_ff;
   logic          mg_neg_ff;
   logic [MW-1:0] mg_mag_ff;
   logic          mg_neg_in;
   logic [MW-1:0] mg_mag_in;

   always_comb begin
      mg_neg_in = sq_p_ff[FRAC_BITS] < 4'd8;
      if (mg_neg_in) begin
         mg_mag_in = (MW'(4'd8 - sq_p_ff[FRAC_BITS]) << FRAC_BITS)
                     - MW'(sq_frac_ff[FRAC_BITS]);
      end else begin
         mg_mag_in = (MW'(sq_p_ff[FRAC_BITS] - 4'd8) << FRAC_BITS)
                     + MW'(sq_frac_ff[FRAC_BITS]);
      end
   end

   // ---------------------------------------------------------------- ln, then T0 * |ln|
   logic          ln_v_ff;
   kind_type      ln_kind_ff;
   logic          ln_neg_ff;
   logic [MW-1:0] ln_mag_ff;
   logic [LPW-1:0] ln_prod;

   logic          tp_v_ff;
   kind_type      tp_kind_ff;
   logic          tp_neg_ff;
   logic [PW-1:0] tp_prod_ff;

   assign ln_prod = LPW'(mg_mag_ff) * LPW'(ntc_pkg::LN2_Q30) + (LPW'(1) << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_v_ff <= 1'b0;
         ln_v_ff <= 1'b0;
         tp_v_ff <= 1'b0;
      end else if (adv) begin
         mg_v_ff <= sq_v_ff[FRAC_BITS];
         ln_v_ff <= mg_v_ff;
         tp_v_ff <= ln_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mg_kind_ff <= sq_kind_ff[FRAC_BITS];
         mg_neg_ff  <= mg_neg_in;
         mg_mag_ff  <= mg_mag_in;
         ln_kind_ff <= mg_kind_ff;
         ln_neg_ff  <= mg_neg_ff;
         ln_mag_ff  <= ln_prod[LPW-1:30];
         tp_kind_ff <= ln_kind_ff;
         tp_neg_ff  <= ln_neg_ff;
         tp_prod_ff <= PW'(t0_ff) * PW'(ln_mag_ff);
      end
   end

   // ---------------------------------------------------------------- divide by 100
   // Long division, four dividend bits per stage; quotient bits replace them.
   logic            h_v_ff    [0:NS];
   kind_type        h_kind_ff [0:NS];
   logic            h_neg_ff  [0:NS];
   logic [PADW-1:0] h_dq_ff   [0:NS];
   logic [6:0]      h_r_ff    [0:NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff[0] <= 1'b0;
      end else if (adv) begin
         h_v_ff[0] <= tp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_kind_ff[0] <= tp_kind_ff;
         h_neg_ff[0]  <= tp_neg_ff;
         h_dq_ff[0]   <= PADW'(tp_prod_ff);
         h_r_ff[0]    <= '0;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_div100
      logic [3:0] nib;
      logic [3:0] qb;
      logic [7:0] r8;
      logic [6:0] r;

      always_comb begin
         nib = h_dq_ff[s][PADW-1 -: 4];
         qb  = '0;
         r   = h_r_ff[s];
         r8  = '0;
         for (int t = 3; t >= 0; t--) begin
            r8 = {r, nib[2'(t)]};
            if (r8 >= 8'd100) begin
               r8 = r8 - 8'd100;
               qb[2'(t)] = 1'b1;
            end
            r = r8[6:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            h_v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            h_v_ff[s+1] <= h_v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            h_kind_ff[s+1] <= h_kind_ff[s];
            h_neg_ff[s+1]  <= h_neg_ff[s];
            h_dq_ff[s+1]   <= {h_dq_ff[s][PADW-5:0], qb};
            h_r_ff[s+1]    <= r;
         end
      end
   end

   // ---------------------------------------------------------------- denominator
   logic                  dn_v_ff;
   kind_type              dn_kind_ff;
   logic signed [DNW-1:0] dn_denom_ff;
   logic signed [DNW-1:0] dn_bs;
   logic signed [DNW-1:0] dn_q;

   always_comb begin
      dn_bs = signed'(DNW'(beta_ff) << FRAC_BITS);
      dn_q  = signed'(DNW'(h_dq_ff[NS]));
   end

   // Stage E2: numerator with half the divisor for rounding
   logic           e2_v_ff;
   kind_type       e2_kind_ff;
   logic           e2_sat_ff;
   logic [DUW-1:0] e2_d_ff;
   logic [NW-1:0]  e2_n_ff;
   logic [DUW-1:0] e2_d_in;

   assign e2_d_in = dn_denom_ff[DUW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
      end else if (adv) begin
         dn_v_ff <= h_v_ff[NS];
         e2_v_ff <= dn_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dn_kind_ff  <= h_kind_ff[NS];
         dn_denom_ff <= h_neg_ff[NS] ? dn_bs - dn_q : dn_bs + dn_q;
         e2_kind_ff  <= dn_kind_ff;
         e2_sat_ff   <= dn_denom_ff[DNW-1] || (dn_denom_ff == '0);
         e2_d_ff     <= e2_d_in;
         e2_n_ff     <= (NW'(numk_ff) << FRAC_BITS) + NW'(e2_d_in >> 1);
      end
   end

   // ---------------------------------------------------------------- kelvin divider
   // Index 0 is stage E3: a quotient of 2^16 or more saturates.
   logic           d2_v_ff    [0:16];
   kind_type       d2_kind_ff [0:16];
   logic           d2_sat_ff  [0:16];
   logic [RW2-1:0] d2_rem_ff  [0:16];
   logic [DUW-1:0] d2_d_ff    [0:16];
   logic [15:0]    d2_q_ff    [0:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff[0] <= 1'b0;
      end else if (adv) begin
         d2_v_ff[0] <= e2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_kind_ff[0] <= e2_kind_ff;
         d2_sat_ff[0]  <= e2_sat_ff || (RW2'(e2_n_ff) >= (RW2'(e2_d_ff) << 16));
         d2_rem_ff[0]  <= RW2'(e2_n_ff);
         d2_d_ff[0]    <= e2_d_ff;
         d2_q_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < 16; k++) begin : g_div2
      logic [RW2-1:0] trial;
      logic           take;

      always_comb begin
         trial = RW2'(d2_d_ff[k]) << (15 - k);
         take  = d2_rem_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            d2_v_ff[k+1] <= d2_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d2_kind_ff[k+1] <= d2_kind_ff[k];
            d2_sat_ff[k+1]  <= d2_sat_ff[k];
            d2_rem_ff[k+1]  <= take ? d2_rem_ff[k] - trial : d2_rem_ff[k];
            d2_d_ff[k+1]    <= d2_d_ff[k];
            d2_q_ff[k+1]    <= {d2_q_ff[k][14:0], take};
         end
      end
   end

   // ---------------------------------------------------------------- output register
   logic [15:0] out_temp;
   logic [16:0] out_diff;
   kind_type    out_kind;
   logic [15:0] rsp_temp_ff;
   kind_type    rsp_kind_ff;

   always_comb begin
      out_kind = d2_kind_ff[16];
      out_diff = 17'(d2_q_ff[16]) - 17'(ntc_pkg::ZERO_C_CK);
      if (out_kind != ntc_pkg::FAULT_NONE) begin
         out_temp = '0;
      end else if (d2_sat_ff[16] || (17'(d2_q_ff[16]) > 17'(ntc_pkg::TCK_MAX))) begin
         out_temp = 16'(ntc_pkg::TEMP_MAX);
      end else begin
         out_temp = out_diff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= d2_v_ff[16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_temp_ff <= out_temp;
         rsp_kind_ff <= out_kind;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_temp_ff;
   assign rsp_tuser  = {rsp_kind_ff, rsp_kind_ff == ntc_pkg::FAULT_NONE};

endmodule

// ===== hw/rtl/ntc_checker.sv =====
module ntc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_ok_vs_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[2:1] == ntc_pkg::FAULT_NONE)))
      else $error("reading_ok disagrees with fault_kind");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("faulted item carries a nonzero temperature");

   a_above_zero_k: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> $signed(rsp_tdata) >= -16'sd27315)
      else $error("temperature below absolute zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

endmodule

bind ntc_adc_to_celsius ntc_checker u_ntc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
